[hw/rtl/mpd_pkg.sv]
// shared types and constants for the mean pixel displacement core
package mpd_pkg;

  // field widths
  localparam int unsigned CoordBits = 16;
  localparam int unsigned DiffBits  = CoordBits;
  localparam int unsigned RadBits   = 2 * DiffBits + 2;
  localparam int unsigned RootBits  = RadBits / 2;
  localparam int unsigned CountBits = 21;
  localparam int unsigned SumBits   = 38;
  localparam int unsigned RemBits   = CountBits;
  localparam int unsigned AluBits   = RemBits + 1;
  localparam int unsigned StepBits  = 5;

  // run limit and iteration counts
  localparam logic [CountBits-1:0] MaxPixels = CountBits'(1048576);
  localparam logic [StepBits-1:0]  LastStep  = StepBits'(RootBits - 1);

  // input word
  typedef struct packed {
    logic signed [CoordBits-1:0] old_x;
    logic signed [CoordBits-1:0] old_y;
    logic signed [CoordBits-1:0] new_x;
    logic signed [CoordBits-1:0] new_y;
    logic                        last_pair;
  } mpd_in_t;

  // result word
  typedef struct packed {
    logic [16:0]          mean_movement;
    logic [CountBits-1:0] pair_count;
    logic                 overflowed;
  } mpd_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } mpd_state_e;

  // absolute difference of two signed coordinates
  function automatic logic [DiffBits-1:0] abs_diff(logic signed [CoordBits-1:0] a,
                                                   logic signed [CoordBits-1:0] b);
    logic signed [CoordBits:0] d;
    logic signed [CoordBits:0] n;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    n = -d;
    return d[CoordBits] ? n[DiffBits-1:0] : d[DiffBits-1:0];
  endfunction

endpackage

[hw/rtl/mpd_sub_unit.sv]
// shared compare and subtract unit used by the root and divide steps
module mpd_sub_unit (
  input  logic [mpd_pkg::AluBits-1:0] a_i,
  input  logic [mpd_pkg::AluBits-1:0] b_i,
  output logic [mpd_pkg::AluBits-1:0] diff_o,
  output logic                        ge_o
);
  import mpd_pkg::*;

  logic [AluBits:0] sub;

  // one wide subtract, borrow gives the compare
  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = sub[AluBits-1:0];
  assign ge_o   = ~sub[AluBits];

endmodule

[hw/rtl/mean_pixel_displacement_core.sv]
// top level of the mean pixel displacement core
//
//  channel | valid       | stall       | word
//  --------+-------------+-------------+-------------------------------------
//  in      | in_valid_i  | in_stall_o  | in_word_i  (old/new x,y, last_pair)
//  out     | out_valid_o | out_stall_i | out_word_o (mean, count, overflow)
//
// each pair goes through the accept, two squaring steps on one 16x16 multiplier,
// 17 root steps on the shared subtract unit and one accumulate. a pair marked last
// adds 17 divide steps on the same unit and a load of the output register. the
// core takes no new pair until it is back in idle.
// reset clears the sequencer, the running sum, the count and the flag.
// a stalled output word holds; the core waits before loading a new one.
module mean_pixel_displacement_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mpd_pkg::mpd_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mpd_pkg::mpd_out_t out_word_o
);
  import mpd_pkg::*;

  mpd_state_e state_q, state_d;

  logic [DiffBits-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic                 last_q, last_d;
  logic [RadBits-1:0]   work_q, work_d;
  logic [RemBits-1:0]   rem_q, rem_d;
  logic [RootBits-1:0]  res_q, res_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic [SumBits-1:0]   sum_q, sum_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  mpd_out_t             out_q, out_d;

  logic                 in_accept;
  logic                 out_free;
  logic                 steps_done;
  logic [DiffBits-1:0]  mul_op;
  logic [2*DiffBits-1:0] mul_prod;
  logic [AluBits-1:0]   alu_a, alu_b, alu_diff;
  logic                 alu_ge;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign steps_done  = (step_q == LastStep);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // single multiplier, squares dx then dy
  assign mul_op   = (state_q == ST_SQX) ? dx_q : dy_q;
  assign mul_prod = mul_op * mul_op;

  // operand select for the shared subtract unit
  always_comb begin
    if (state_q == ST_DIV) begin
      alu_a = {rem_q, work_q[RootBits-1]};
      alu_b = {1'b0, cnt_q};
    end else begin
      alu_a = AluBits'({rem_q[RemBits-3:0], work_q[RadBits-1 -: 2]});
      alu_b = AluBits'({res_q, 2'b01});
    end
  end

  mpd_sub_unit u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .diff_o(alu_diff),
    .ge_o  (alu_ge)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_ROOT;
      ST_ROOT: if (steps_done) state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (steps_done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    logic [SumBits-1:0]   new_sum;
    logic [CountBits-1:0] new_cnt;
    dx_d        = dx_q;
    dy_d        = dy_q;
    last_d      = last_q;
    work_d      = work_q;
    rem_d       = rem_q;
    res_d       = res_q;
    step_d      = step_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    new_sum     = sum_q;
    new_cnt     = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          dx_d   = abs_diff(in_word_i.old_x, in_word_i.new_x);
          dy_d   = abs_diff(in_word_i.old_y, in_word_i.new_y);
          last_d = in_word_i.last_pair;
        end
      end
      ST_SQX: begin
        work_d = RadBits'(mul_prod);
      end
      ST_SQY: begin
        work_d = work_q + RadBits'(mul_prod);
        rem_d  = '0;
        res_d  = '0;
        step_d = '0;
      end
      ST_ROOT: begin
        // one root bit per cycle, two radicand bits shifted in
        work_d = {work_q[RadBits-3:0], 2'b00};
        step_d = step_q + StepBits'(1);
        if (alu_ge) begin
          rem_d = alu_diff[RemBits-1:0];
          res_d = {res_q[RootBits-2:0], 1'b1};
        end else begin
          rem_d = alu_a[RemBits-1:0];
          res_d = {res_q[RootBits-2:0], 1'b0};
        end
      end
      ST_ACC: begin
        // drop pairs beyond the run limit
        if (cnt_q < MaxPixels) begin
          new_sum = sum_q + SumBits'(res_q);
          new_cnt = cnt_q + CountBits'(1);
        end else begin
          ovf_d = 1'b1;
        end
        sum_d  = new_sum;
        cnt_d  = new_cnt;
        // high sum bits start below the count, so 17 quotient bits suffice
        rem_d  = new_sum[SumBits-1 -: RemBits];
        work_d = RadBits'(new_sum[RootBits-1:0]);
        res_d  = '0;
        step_d = '0;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        work_d = {work_q[RadBits-2:0], 1'b0};
        step_d = step_q + StepBits'(1);
        if (alu_ge) begin
          rem_d = alu_diff[RemBits-1:0];
          res_d = {res_q[RootBits-2:0], 1'b1};
        end else begin
          rem_d = alu_a[RemBits-1:0];
          res_d = {res_q[RootBits-2:0], 1'b0};
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_d.mean_movement = (cnt_q != '0) ? res_q : '0;
          out_d.pair_count    = cnt_q;
          out_d.overflowed    = ovf_q;
          out_valid_d         = 1'b1;
          sum_d               = '0;
          cnt_d               = '0;
          ovf_d               = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    last_q <= last_d;
    work_q <= work_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    step_q <= step_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("core took a word while busy");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxPixels)
    else $error("pair count above run limit");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < cnt_q))
    else $error("divide remainder not below count");

  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.pair_count != '0))
    else $error("result word with zero pair count");

  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (cnt_q == '0 && sum_q == '0 && !ovf_q))
    else $error("run state not cleared after result");
`endif

endmodule

[test/tb_mean_pixel_displacement_core.sv]
// testbench for the mean pixel displacement core: directed table, random runs, scoreboard
module tb_mean_pixel_displacement_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mpd_pkg::*;

  localparam int RandomWords = 800;
  localparam int CalmWords   = 100;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 60;
  localparam int NumRows     = 16;

  // one row of directed stimulus; res is used only when typed is set
  typedef struct packed {
    mpd_in_t  word;
    logic     typed;
    mpd_out_t res;
  } stim_row_t;

  // old_x, old_y, new_x, new_y, last_pair | typed | mean, count, overflow
  localparam stim_row_t DirectedRows [NumRows] = '{
    // lone marked pair with no movement
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{17'd0, 21'd1, 1'b0}},
    // widest diagonal, both directions
    '{'{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1}, 1'b1, '{17'd92680, 21'd1, 1'b0}},
    '{'{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1}, 1'b1, '{17'd92680, 21'd1, 1'b0}},
    // extreme coordinates that do not move
    '{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1}, 1'b1, '{17'd0, 21'd1, 1'b0}},
    // 3-4-5 triangle, 48 and 64 pixels
    '{'{16'h0000, 16'h0000, 16'd48, 16'd64, 1'b1}, 1'b1, '{17'd80, 21'd1, 1'b0}},
    // two pairs: half range in x, full range in y
    '{'{16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 1'b1}, 1'b1, '{17'd49151, 21'd2, 1'b0}},
    // three pairs averaged
    '{'{16'h0000, 16'h0000, 16'd16, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'd32, 1'b0}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{17'd16, 21'd3, 1'b0}},
    // mean truncates toward zero
    '{'{16'h0000, 16'h0000, 16'd1, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{17'd0, 21'd2, 1'b0}},
    // root truncates
    '{'{16'h0000, 16'h0000, 16'd1, 16'd1, 1'b1}, 1'b1, '{17'd1, 21'd1, 1'b0}},
    // mixed signs, left to the predictor
    '{'{16'd1234, 16'hFDC9, 16'hFC86, 16'd4321, 1'b0}, 1'b0, '0},
    '{'{16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 1'b0}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1}, 1'b0, '0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  mpd_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mpd_out_t out_word;

  // predicted core state
  logic [SumBits-1:0]   dist_sum;
  logic [CountBits-1:0] pairs_counted;
  logic                 run_overflow;

  mpd_out_t    mean_queue [$];
  int          error_count = 0;
  bit          idle_on     = 1'b1;
  int unsigned cycle_count = 0;

  mean_pixel_displacement_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // truncated square root, one result bit per step from the top
  function automatic logic [16:0] floor_root(logic [33:0] n);
    logic [16:0] r;
    logic [33:0] t;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = 34'(r | (17'd1 << b));
      if (t * t <= n) r = t[16:0];
    end
    return r;
  endfunction

  // dx squared plus dy squared
  function automatic logic [33:0] squared_span(mpd_in_t w);
    int dx;
    int dy;
    dx = int'($signed(w.old_x)) - int'($signed(w.new_x));
    dy = int'($signed(w.old_y)) - int'($signed(w.new_y));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return 34'(longint'(dx) * dx + longint'(dy) * dy);
  endfunction

  // fold one accepted pair into the predicted state
  task automatic account_pair(input stim_row_t row);
    mpd_out_t want;
    if (pairs_counted < MaxPixels) begin
      dist_sum      = dist_sum + SumBits'(floor_root(squared_span(row.word)));
      pairs_counted = pairs_counted + 1'b1;
    end else begin
      run_overflow = 1'b1;
    end
    if (row.word.last_pair) begin
      want.mean_movement = 17'(dist_sum / SumBits'(pairs_counted));
      want.pair_count    = pairs_counted;
      want.overflowed    = run_overflow;
      mean_queue.insert(mean_queue.size(), row.typed ? row.res : want);
      dist_sum      = '0;
      pairs_counted = '0;
      run_overflow  = 1'b0;
    end
  endtask

  // drive one word, with an optional idle burst ahead of it
  task automatic send_pair(input stim_row_t row);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_word  <= row.word;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_pair(row);
  endtask

  // random pair: full range, short moves, corners or no move
  function automatic mpd_in_t random_pair(bit last);
    mpd_in_t     w;
    logic [15:0] corner [4];
    corner = '{16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF};
    w.old_x = 16'($urandom);
    w.old_y = 16'($urandom);
    w.new_x = 16'($urandom);
    w.new_y = 16'($urandom);
    case ($urandom_range(0, 9))
      4, 5, 6, 7: begin
        w.new_x = w.old_x + 16'($urandom_range(0, 511)) - 16'd256;
        w.new_y = w.old_y + 16'($urandom_range(0, 511)) - 16'd256;
      end
      8: begin
        w.old_x = corner[$urandom_range(0, 3)];
        w.old_y = corner[$urandom_range(0, 3)];
        w.new_x = corner[$urandom_range(0, 3)];
        w.new_y = corner[$urandom_range(0, 3)];
      end
      9: begin
        w.new_x = w.old_x;
        w.new_y = w.old_y;
      end
      default: ;
    endcase
    w.last_pair = last;
    return w;
  endfunction

  // stimulus and end of run
  initial begin : stimulus
    stim_row_t row;
    int        sent;
    int        run_len;
    dist_sum      = '0;
    pairs_counted = '0;
    run_overflow  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumRows; i++) send_pair(DirectedRows[i]);
    sent = 0;
    while (sent < RandomWords) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int k = 0; k < run_len; k++) begin
        if (sent >= RandomWords - CalmWords) idle_on = 1'b0;
        row      = '0;
        row.word = random_pair(k == run_len - 1);
        send_pair(row);
        sent++;
      end
    end
    in_valid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // output stall bursts
  initial begin : sink_idling
    @(posedge rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : result_check
    mpd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_queue.size() == 0) begin
        report_mismatch("unexpected word, mean", out_word.mean_movement, 0);
      end else begin
        want = mean_queue.pop_front();
        if (out_word.mean_movement !== want.mean_movement)
          report_mismatch("mean_movement", out_word.mean_movement, want.mean_movement);
        if (out_word.pair_count !== want.pair_count)
          report_mismatch("pair_count", out_word.pair_count, want.pair_count);
        if (out_word.overflowed !== want.overflowed)
          report_mismatch("overflowed", out_word.overflowed, want.overflowed);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               mean_queue.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

[filelist.f]
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_sub_unit.sv
hw/rtl/mean_pixel_displacement_core.sv
test/tb_mean_pixel_displacement_core.sv
